// ----- rtl/core/gss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg: shared types and constants of the golden-section minimizer
// Word formats, configuration set, sequencer states and fixed-point helpers.
// ----------------------------------------------------------------------------
package gss_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 64;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	// 1/phi^2 in Q0.32, fits in 31 bits
	localparam logic [30:0] RATIO_Q32 = 31'd1640531527;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic signed [31:0] COEF_SQ_RST    = 32'sd65536;
	localparam logic signed [31:0] COEF_LIN_RST   = -32'sd262144;
	localparam logic signed [31:0] COEF_CONST_RST = -32'sd655360;
	localparam logic [30:0]        TOL_RST        = 31'd1;

	typedef enum logic [1:0] {
		REG_COEF_SQ    = 2'd0,
		REG_COEF_LIN   = 2'd1,
		REG_COEF_CONST = 2'd2,
		REG_TOLERANCE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] left_end;
		logic signed [31:0] right_end;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] min_location;
		logic               step_limit_hit;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] coef_sq;
		logic signed [31:0] coef_lin;
		logic signed [31:0] coef_const;
		logic [30:0]        tolerance;
	} cfg_t;

	typedef enum logic {
		MUL_QMUL = 1'b0,
		MUL_OFS  = 1'b1
	} mul_mode_t;

	typedef struct packed {
		mul_mode_t                mode;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic signed [31:0] qres;
		logic [31:0]        ofs;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFS,
		ST_INIT,
		ST_SQ,
		ST_T1,
		ST_T2,
		ST_CHECK
	} st_t;

	typedef enum logic [1:0] {
		PH_INIT1,
		PH_INIT2,
		PH_STEP
	} ph_t;

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/golden_section_minimizer_top.sv -----
`timescale 1ns / 1ps
// Search: N shrink steps run between input accept and result valid (at most
//   MAX_STEPS, about 46 for a full Q16.16 range).
// Flow: one word at a time, input stalls until the search ends
//   and the result word fits; each step runs the sequencer states SQ, T1, T2 (three
//   multiplier passes for the objective), OFS (one for the offset) and CHECK.
// Reset: arst_n clears the sequencer and output valid and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// golden_section_minimizer_top: golden-section search for a quadratic minimum
// Configuration registers, sequencer and one-word output register.
// ----------------------------------------------------------------------------
module golden_section_minimizer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gss_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output gss_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	gss_pkg::cfg_t      cfg_q;
	gss_pkg::out_word_t out_data_q;
	gss_pkg::out_word_t res_data;
	logic               out_valid_q;
	logic               busy;
	logic               res_done;
	logic               start;

	assign in_stall  = busy;
	assign start     = in_valid && !busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_sq    <= gss_pkg::COEF_SQ_RST;
			cfg_q.coef_lin   <= gss_pkg::COEF_LIN_RST;
			cfg_q.coef_const <= gss_pkg::COEF_CONST_RST;
			cfg_q.tolerance  <= gss_pkg::TOL_RST;
		end else if (cfg_we) begin
			case (gss_pkg::reg_idx_t'(cfg_index))
				gss_pkg::REG_COEF_SQ:    cfg_q.coef_sq    <= cfg_data;
				gss_pkg::REG_COEF_LIN:   cfg_q.coef_lin   <= cfg_data;
				gss_pkg::REG_COEF_CONST: cfg_q.coef_const <= cfg_data;
				gss_pkg::REG_TOLERANCE:  cfg_q.tolerance  <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	gss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.start_data(in_data),
		.out_hold  (out_valid_q && out_stall),
		.busy      (busy),
		.res_done  (res_done),
		.res_data  (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			out_data_q <= res_data;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer not busy after accepting a word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |-> !(out_valid && out_stall))
		else $error("result would overwrite a stalled output word");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("sequencer not idle when a result is shown");
`endif

endmodule

// ----- rtl/core/gss_mul_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_mul_unit: shared multiplier
// One signed 33x33 product, with either fixed-point rounding and saturation
// or the Q0.32 offset scaling of the interval width.
// ----------------------------------------------------------------------------
module gss_mul_unit (
	input  gss_pkg::mul_req_t req,
	output gss_pkg::mul_rsp_t rsp
);

	localparam int PW = gss_pkg::PROD_W;
	localparam logic signed [PW-1:0] RND = PW'(1) <<< (gss_pkg::FRAC_BITS - 1);
	localparam logic signed [PW-1:0] OFS_RND = PW'(1) <<< 31;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rounded;
	logic signed [PW-1:0] shifted;
	logic [PW-1:0]        ofs_sum;

	assign prod    = req.a * req.b;
	assign rounded = prod + RND;
	assign shifted = rounded >>> gss_pkg::FRAC_BITS;
	assign ofs_sum = $unsigned(prod + OFS_RND);

	always_comb begin
		if ((&shifted[PW-1:31]) || !(|shifted[PW-1:31])) begin
			rsp.qres = shifted[31:0];
		end else if (shifted[PW-1]) begin
			rsp.qres = 32'sh8000_0000;
		end else begin
			rsp.qres = 32'sh7FFF_FFFF;
		end
		rsp.ofs = (req.mode == gss_pkg::MUL_OFS) ? ofs_sum[63:32] : '0;
	end

endmodule

// ----- rtl/core/gss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_ctrl: search sequencer and datapath
// Holds the probes, their objective values, width and offset, and walks the
// shared multiplier through each objective evaluation and offset update.
// ----------------------------------------------------------------------------
module gss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  gss_pkg::cfg_t      cfg,
	input  logic               start,
	input  gss_pkg::in_word_t  start_data,
	input  logic               out_hold,
	output logic               busy,
	output logic               res_done,
	output gss_pkg::out_word_t res_data
);

	gss_pkg::st_t state_q, state_d;
	gss_pkg::ph_t phase_q, phase_d;

	logic signed [31:0] p1_q, p2_q, f1_q, f2_q, x_q, sq_q, acc_q;
	logic [31:0]        width_q, d_q;
	logic [gss_pkg::STEP_W-1:0] steps_q;
	logic               upd_f1_q;

	gss_pkg::mul_req_t mul_req;
	gss_pkg::mul_rsp_t mul_rsp;

	logic signed [31:0] fx;
	logic signed [31:0] p1_plus_d, p2_minus_d;
	logic               width_ok, limit_reached, finish;
	logic signed [31:0] lo, hi;

	gss_mul_unit u_mul (
		.req(mul_req),
		.rsp(mul_rsp)
	);

	assign fx = gss_pkg::sat34(34'(acc_q) + 34'(mul_rsp.qres) + 34'(cfg.coef_const));
	assign p1_plus_d  = gss_pkg::sat34(34'(p1_q) + $signed({2'b00, d_q}));
	assign p2_minus_d = gss_pkg::sat34(34'(p2_q) - $signed({2'b00, d_q}));

	assign width_ok      = width_q <= {1'b0, cfg.tolerance};
	assign limit_reached = steps_q >= gss_pkg::STEP_W'(gss_pkg::MAX_STEPS);
	assign finish        = width_ok || limit_reached;

	assign lo = (start_data.left_end > start_data.right_end) ? start_data.right_end
	                                                         : start_data.left_end;
	assign hi = (start_data.left_end > start_data.right_end) ? start_data.left_end
	                                                         : start_data.right_end;

	assign busy = state_q != gss_pkg::ST_IDLE;
	assign res_data.min_location   = p1_q;
	assign res_data.step_limit_hit = !width_ok;

	always_comb begin
		mul_req.mode = gss_pkg::MUL_QMUL;
		mul_req.a    = '0;
		mul_req.b    = '0;
		case (state_q)
			gss_pkg::ST_OFS: begin
				mul_req.mode = gss_pkg::MUL_OFS;
				mul_req.a    = $signed({1'b0, width_q});
				mul_req.b    = $signed({2'b00, gss_pkg::RATIO_Q32});
			end
			gss_pkg::ST_SQ: begin
				mul_req.a = 33'(x_q);
				mul_req.b = 33'(x_q);
			end
			gss_pkg::ST_T1: begin
				mul_req.a = 33'(cfg.coef_sq);
				mul_req.b = 33'(sq_q);
			end
			gss_pkg::ST_T2: begin
				mul_req.a = 33'(cfg.coef_lin);
				mul_req.b = 33'(x_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		res_done = 1'b0;
		case (state_q)
			gss_pkg::ST_IDLE: begin
				if (start) begin
					state_d = gss_pkg::ST_OFS;
					phase_d = gss_pkg::PH_INIT1;
				end
			end
			gss_pkg::ST_OFS: begin
				state_d = (phase_q == gss_pkg::PH_INIT1) ? gss_pkg::ST_INIT
				                                         : gss_pkg::ST_CHECK;
			end
			gss_pkg::ST_INIT: state_d = gss_pkg::ST_SQ;
			gss_pkg::ST_SQ:   state_d = gss_pkg::ST_T1;
			gss_pkg::ST_T1:   state_d = gss_pkg::ST_T2;
			gss_pkg::ST_T2: begin
				case (phase_q)
					gss_pkg::PH_INIT1: begin
						state_d = gss_pkg::ST_SQ;
						phase_d = gss_pkg::PH_INIT2;
					end
					gss_pkg::PH_INIT2: state_d = gss_pkg::ST_CHECK;
					default:           state_d = gss_pkg::ST_OFS;
				endcase
			end
			gss_pkg::ST_CHECK: begin
				if (finish) begin
					// hold the result until the output register frees up
					if (!out_hold) begin
						res_done = 1'b1;
						state_d  = gss_pkg::ST_IDLE;
					end
				end else begin
					state_d = gss_pkg::ST_SQ;
					phase_d = gss_pkg::PH_STEP;
				end
			end
			default: state_d = gss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gss_pkg::ST_IDLE;
			phase_q <= gss_pkg::PH_INIT1;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gss_pkg::ST_IDLE: begin
				if (start) begin
					p1_q    <= lo;
					p2_q    <= hi;
					width_q <= 32'($signed({hi[31], hi}) - $signed({lo[31], lo}));
					steps_q <= '0;
				end
			end
			gss_pkg::ST_OFS: d_q <= mul_rsp.ofs;
			gss_pkg::ST_INIT: begin
				p1_q <= p1_plus_d;
				p2_q <= p2_minus_d;
				x_q  <= p1_plus_d;
			end
			gss_pkg::ST_SQ: sq_q  <= mul_rsp.qres;
			gss_pkg::ST_T1: acc_q <= mul_rsp.qres;
			gss_pkg::ST_T2: begin
				case (phase_q)
					gss_pkg::PH_INIT1: begin
						f1_q <= fx;
						x_q  <= p2_q;
					end
					gss_pkg::PH_INIT2: f2_q <= fx;
					default: begin
						if (upd_f1_q) begin
							f1_q <= fx;
						end else begin
							f2_q <= fx;
						end
					end
				endcase
			end
			gss_pkg::ST_CHECK: begin
				if (!finish) begin
					// keep the side holding the smaller probe value
					if (f1_q < f2_q) begin
						p2_q     <= p1_q;
						p1_q     <= p2_minus_d;
						x_q      <= p2_minus_d;
						f2_q     <= f1_q;
						upd_f1_q <= 1'b1;
					end else begin
						p1_q     <= p2_q;
						p2_q     <= p1_plus_d;
						x_q      <= p1_plus_d;
						f1_q     <= f2_q;
						upd_f1_q <= 1'b0;
					end
					width_q <= width_q - d_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
